@@ hw/rtl/tsss_pkg.sv @@
// Shared constants, types and saturation helper for the split score search.
package tsss_pkg;

  localparam int unsigned DEPTH     = 3;
  localparam int unsigned CELL_W    = DEPTH;
  localparam int unsigned NUM_CELLS = 1 << DEPTH;
  localparam int unsigned ACC_W     = 48;
  localparam int unsigned OUT_W     = 32;
  localparam int unsigned COMB_W    = 16;
  localparam int unsigned EXT_W     = ACC_W + 1 - OUT_W;

  localparam logic [CELL_W-1:0] LAST_CELL = CELL_W'(NUM_CELLS - 1);

  // Write request from the accumulate stage to one accumulator bank.
  typedef struct packed {
    logic              we;
    logic [CELL_W-1:0] addr;
    logic [ACC_W-1:0]  data;
  } wr_req_t;

  // Clamp a sum that has grown by one bit back into the signed accumulator range.
  function automatic logic signed [ACC_W-1:0] sat_acc(input logic signed [ACC_W:0] v);
    logic signed [ACC_W-1:0] r;
    if (v[ACC_W] != v[ACC_W-1]) begin
      r = {v[ACC_W], {(ACC_W-1){~v[ACC_W]}}};
    end else begin
      r = v[ACC_W-1:0];
    end
    return r;
  endfunction

endpackage

@@ hw/rtl/tsss_bank.sv @@
// One accumulator bank: per-cell totals in a synchronous memory with valid bits and forwarding.
module tsss_bank (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic [tsss_pkg::CELL_W-1:0]          raddr_i,
  input  tsss_pkg::wr_req_t                    wr_i,
  input  logic                                 clear_i,
  output logic signed [tsss_pkg::ACC_W-1:0]    rdata_o
);

  logic [tsss_pkg::ACC_W-1:0]     mem_q [tsss_pkg::NUM_CELLS];
  logic [tsss_pkg::ACC_W-1:0]     rd_q;
  logic [tsss_pkg::ACC_W-1:0]     hit_data_q;
  logic [tsss_pkg::NUM_CELLS-1:0] vld_q;
  logic                           rd_vld_q;
  logic                           hit_q;

  always_ff @(posedge clk_i) begin
    if (wr_i.we) begin
      mem_q[wr_i.addr] <= wr_i.data;
    end
    rd_q       <= mem_q[raddr_i];
    hit_data_q <= wr_i.data;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q    <= '0;
      rd_vld_q <= 1'b0;
      hit_q    <= 1'b0;
    end else begin
      rd_vld_q <= vld_q[raddr_i];
      // a write to the entry being read lands at the same edge: forward it
      hit_q    <= wr_i.we && (wr_i.addr == raddr_i);
      if (clear_i) begin
        vld_q <= '0;
      end else if (wr_i.we) begin
        vld_q[wr_i.addr] <= 1'b1;
      end
    end
  end

  // an entry never written since the last clear reads as zero
  assign rdata_o = hit_q ? hit_data_q : (rd_vld_q ? rd_q : '0);

endmodule

@@ hw/rtl/treatment_split_score_search.sv @@
// Top level of the treatment split score search.
// Usage: samples of one cut combination enter on start; a sample is transferred
// at a rising edge with start high and busy low. Each sample adds its outcome to
// the treated or untreated total of its cell, with saturation. Samples without
// last_sample_i are taken one per cycle and give no result.
// A sample with last_sample_i raises busy: the cell scan reads both accumulator
// banks once per cell, then the maximum, offset and group best stages follow.
// The result is shown for one cycle with res_strobe_o, in the first cycle busy
// is low again, so a new sample can be transferred in that same cycle. The scan
// length is set by the single read port of each bank.
// The receiver cannot stall; the result outputs hold until the next result.
// score_offset_i is written at any edge with score_offset_we_i high; write it
// only while the block is idle.
// Reset clears the totals (through per-cell valid bits), the group best and
// the offset; the block is ready in the first cycle after reset.
module treatment_split_score_search (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                score_offset_we_i,
  input  logic signed [tsss_pkg::OUT_W-1:0]   score_offset_i,
  input  logic                                start,
  output logic                                busy,
  input  logic                                treatment_i,
  input  logic [tsss_pkg::CELL_W-1:0]         cell_index_i,
  input  logic signed [tsss_pkg::OUT_W-1:0]   outcome_i,
  input  logic                                last_sample_i,
  input  logic [tsss_pkg::COMB_W-1:0]         combination_id_i,
  input  logic                                last_in_group_i,
  output logic                                res_strobe_o,
  output logic signed [tsss_pkg::ACC_W-1:0]   combination_score_o,
  output logic [tsss_pkg::CELL_W-1:0]         combination_cell_o,
  output logic signed [tsss_pkg::ACC_W-1:0]   best_score_o,
  output logic [tsss_pkg::CELL_W-1:0]         best_cell_o,
  output logic [tsss_pkg::COMB_W-1:0]         best_combination_o,
  output logic                                group_done_o
);

  logic accept;

  // accumulate stage
  logic                                smp_vld_q;
  logic                                smp_treat_q;
  logic [tsss_pkg::CELL_W-1:0]         smp_cell_q;
  logic signed [tsss_pkg::OUT_W-1:0]   smp_out_q;
  logic signed [tsss_pkg::ACC_W-1:0]   acc_op;
  logic signed [tsss_pkg::ACC_W-1:0]   acc_sum;

  // scan and reduce stages
  logic                                scan_act_q;
  logic [tsss_pkg::CELL_W-1:0]         scan_cell_q;
  logic                                cmp_vld_q;
  logic [tsss_pkg::CELL_W-1:0]         cmp_cell_q;
  logic signed [tsss_pkg::ACC_W-1:0]   diff_d;
  logic signed [tsss_pkg::ACC_W-1:0]   diff_q;
  logic                                diff_vld_q;
  logic [tsss_pkg::CELL_W-1:0]         diff_cell_q;
  logic signed [tsss_pkg::ACC_W-1:0]   max_q;
  logic [tsss_pkg::CELL_W-1:0]         max_cell_q;
  logic                                fin_vld_q;
  logic signed [tsss_pkg::ACC_W-1:0]   score_d;
  logic signed [tsss_pkg::ACC_W-1:0]   score_q;
  logic                                sc_vld_q;

  // combination and group state
  logic                                busy_q;
  logic [tsss_pkg::COMB_W-1:0]         comb_q;
  logic                                lig_q;
  logic signed [tsss_pkg::OUT_W-1:0]   offset_q;
  logic signed [tsss_pkg::ACC_W-1:0]   best_q;
  logic [tsss_pkg::CELL_W-1:0]         best_cell_q;
  logic [tsss_pkg::COMB_W-1:0]         best_comb_q;
  logic                                new_best;
  logic                                res_strobe_q;
  logic signed [tsss_pkg::ACC_W-1:0]   res_score_q;
  logic [tsss_pkg::CELL_W-1:0]         res_cell_q;
  logic signed [tsss_pkg::ACC_W-1:0]   res_best_q;
  logic [tsss_pkg::CELL_W-1:0]         res_best_cell_q;
  logic [tsss_pkg::COMB_W-1:0]         res_best_comb_q;
  logic                                res_done_q;

  // accumulator banks: index 0 untreated, 1 treated
  logic [tsss_pkg::CELL_W-1:0]         raddr;
  tsss_pkg::wr_req_t                   wr0;
  tsss_pkg::wr_req_t                   wr1;
  logic signed [tsss_pkg::ACC_W-1:0]   rdata0;
  logic signed [tsss_pkg::ACC_W-1:0]   rdata1;
  logic                                bank_clear;

  assign accept = start && !busy_q;
  assign busy   = busy_q;

  assign raddr      = scan_act_q ? scan_cell_q : cell_index_i;
  assign bank_clear = scan_act_q && (scan_cell_q == tsss_pkg::LAST_CELL);

  assign acc_op  = smp_treat_q ? rdata1 : rdata0;
  assign acc_sum = tsss_pkg::sat_acc({acc_op[tsss_pkg::ACC_W-1], acc_op}
                     + {{tsss_pkg::EXT_W{smp_out_q[tsss_pkg::OUT_W-1]}}, smp_out_q});

  assign wr0.we   = smp_vld_q && !smp_treat_q;
  assign wr0.addr = smp_cell_q;
  assign wr0.data = acc_sum;
  assign wr1.we   = smp_vld_q && smp_treat_q;
  assign wr1.addr = smp_cell_q;
  assign wr1.data = acc_sum;

  tsss_bank u_bank0 (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .raddr_i (raddr),
    .wr_i    (wr0),
    .clear_i (bank_clear),
    .rdata_o (rdata0)
  );

  tsss_bank u_bank1 (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .raddr_i (raddr),
    .wr_i    (wr1),
    .clear_i (bank_clear),
    .rdata_o (rdata1)
  );

  assign diff_d  = tsss_pkg::sat_acc({rdata1[tsss_pkg::ACC_W-1], rdata1}
                     - {rdata0[tsss_pkg::ACC_W-1], rdata0});
  assign score_d = tsss_pkg::sat_acc({max_q[tsss_pkg::ACC_W-1], max_q}
                     + {{tsss_pkg::EXT_W{offset_q[tsss_pkg::OUT_W-1]}}, offset_q});
  assign new_best = score_q > best_q;

  // payload registers
  always_ff @(posedge clk_i) begin
    if (accept) begin
      smp_treat_q <= treatment_i;
      smp_cell_q  <= cell_index_i;
      smp_out_q   <= outcome_i;
      if (last_sample_i) begin
        comb_q <= combination_id_i;
        lig_q  <= last_in_group_i;
      end
    end
    cmp_cell_q  <= scan_cell_q;
    diff_q      <= diff_d;
    diff_cell_q <= cmp_cell_q;
    // first cell on ties: only a strictly larger difference replaces the maximum
    if (diff_vld_q && ((diff_cell_q == '0) || (diff_q > max_q))) begin
      max_q      <= diff_q;
      max_cell_q <= diff_cell_q;
    end
    score_q <= score_d;
    if (sc_vld_q) begin
      res_score_q     <= score_q;
      res_cell_q      <= max_cell_q;
      res_best_q      <= new_best ? score_q : best_q;
      res_best_cell_q <= new_best ? max_cell_q : best_cell_q;
      res_best_comb_q <= new_best ? comb_q : best_comb_q;
      res_done_q      <= lig_q;
    end
  end

  // control and group state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      smp_vld_q    <= 1'b0;
      scan_act_q   <= 1'b0;
      scan_cell_q  <= '0;
      cmp_vld_q    <= 1'b0;
      diff_vld_q   <= 1'b0;
      fin_vld_q    <= 1'b0;
      sc_vld_q     <= 1'b0;
      busy_q       <= 1'b0;
      res_strobe_q <= 1'b0;
      offset_q     <= '0;
      best_q       <= '0;
      best_cell_q  <= '0;
      best_comb_q  <= '0;
    end else begin
      smp_vld_q  <= accept;
      cmp_vld_q  <= scan_act_q;
      diff_vld_q <= cmp_vld_q;
      fin_vld_q  <= diff_vld_q && (diff_cell_q == tsss_pkg::LAST_CELL);
      sc_vld_q   <= fin_vld_q;
      res_strobe_q <= sc_vld_q;

      if (score_offset_we_i) begin
        offset_q <= score_offset_i;
      end

      if (accept && last_sample_i) begin
        busy_q      <= 1'b1;
        scan_act_q  <= 1'b1;
        scan_cell_q <= '0;
      end else if (scan_act_q) begin
        scan_cell_q <= scan_cell_q + tsss_pkg::CELL_W'(1);
        if (scan_cell_q == tsss_pkg::LAST_CELL) begin
          scan_act_q <= 1'b0;
        end
      end

      if (sc_vld_q) begin
        busy_q <= 1'b0;
        if (lig_q) begin
          best_q      <= '0;
          best_cell_q <= '0;
          best_comb_q <= '0;
        end else if (new_best) begin
          best_q      <= score_q;
          best_cell_q <= max_cell_q;
          best_comb_q <= comb_q;
        end
      end
    end
  end

  assign res_strobe_o        = res_strobe_q;
  assign combination_score_o = res_score_q;
  assign combination_cell_o  = res_cell_q;
  assign best_score_o        = res_best_q;
  assign best_cell_o         = res_best_cell_q;
  assign best_combination_o  = res_best_comb_q;
  assign group_done_o        = res_done_q;

`ifndef ASSERT_OFF
  a_strobe_ends_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_strobe_q |-> !busy_q && $past(busy_q))
    else $error("result strobe without a preceding busy period");

  a_scan_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (scan_act_q || cmp_vld_q || diff_vld_q || fin_vld_q || sc_vld_q) |-> busy_q)
    else $error("scan stage active while not busy");

  a_no_write_on_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    bank_clear |-> !smp_vld_q)
    else $error("accumulator write collides with bank clear");

  a_best_nonneg: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !best_q[tsss_pkg::ACC_W-1])
    else $error("group best went negative");

  a_group_reset: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (sc_vld_q && lig_q) |=> (best_q == '0) && (best_comb_q == '0))
    else $error("group best not cleared at group end");
`endif

endmodule
